@@ rtl/skf_pkg.sv @@
// shared constants and types of the scalar kalman filter
// no dependencies
package skf_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int DATA_W    = 32;
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_Q  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_R  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_P0 = 2'd2;

  localparam logic [DATA_W-1:0] Q_RST  = 32'd1;
  localparam logic [DATA_W-1:0] R_RST  = 32'd65536;
  localparam logic [DATA_W-1:0] P0_RST = 32'd65536;

  typedef struct packed {
    logic load_in;
    logic div_start;
    logic mul_en;
    logic upd_en;
  } skf_cmd_t;

  typedef struct packed {
    logic div_done;
  } skf_sts_t;

endpackage

@@ rtl/skf_div.sv @@
// restoring divider for the gain: floor(num * 2^GAIN_FRAC / den), one bit per cycle
// depends on skf_pkg
module skf_div import skf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W:0]   den,
  output logic              done,
  output logic [GAIN_W-1:0] quot
);

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic              busy_r;
  logic              done_r;
  logic              zero_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W+1:0] rem_r;
  logic [DATA_W:0]   den_r;
  logic [GAIN_W-1:0] q_r;

  logic              ge;
  logic [DATA_W+1:0] diff;
  logic [DATA_W+1:0] rem_sel;
  logic [DATA_W+1:0] rem_nxt;

  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    diff    = rem_r - {1'b0, den_r};
    rem_sel = ge ? diff : rem_r;
    // remainder stays below den, so one bit of headroom covers the shift
    rem_nxt = {rem_sel[DATA_W:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(GAIN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, num};
      den_r  <= den;
      zero_r <= (den == '0);
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[GAIN_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = zero_r ? '0 : q_r;

endmodule

@@ rtl/skf_dp.sv @@
// datapath: estimate and covariance state, prediction, gain divider, update multipliers
// depends on skf_pkg and skf_div
module skf_dp import skf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  skf_cmd_t               cmd,
  output skf_sts_t               sts,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  input  logic [DATA_W-1:0]      cfg_q,
  input  logic [DATA_W-1:0]      cfg_r,
  input  logic                   init_we,
  input  logic [DATA_W-1:0]      init_val,
  output logic [DATA_W-1:0]      est_out,
  output logic [GAIN_W-1:0]      gain_out
);

  localparam int SW    = SAMPLE_BITS + FRAC_BITS;
  localparam int XW    = (SW > DATA_W) ? SW : DATA_W + 1;
  localparam int PE_W  = GAIN_W + DATA_W + 2;
  localparam int PC_W  = GAIN_W + DATA_W;

  localparam logic signed [XW-1:0] SMAX = XW'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);
  localparam logic signed [PE_W-1:0] EMAX = PE_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [PE_W-1:0] EMIN = -EMAX - PE_W'(1);

  logic signed [DATA_W-1:0]      est_r;
  logic [DATA_W-1:0]             cov_r;
  logic [SAMPLE_BITS-1:0]        samp_r;
  logic [DATA_W-1:0]             pred_r;
  logic signed [PE_W-1:0]        prod_est_r;
  logic [PC_W-1:0]               prod_cov_r;
  logic [GAIN_W-1:0]             gain_r;
  logic [GAIN_W-1:0]             out_gain_r;

  logic [DATA_W:0]               pred_sum;
  logic [DATA_W-1:0]             pred_nxt;
  logic [DATA_W:0]               den;
  logic [GAIN_W-1:0]             quot;
  logic signed [XW-1:0]          sfix_wide;
  logic signed [DATA_W-1:0]      sfix;
  logic signed [DATA_W:0]        innov;
  logic signed [PE_W-1:0]        prod_est_nxt;
  logic [PC_W-1:0]               prod_cov_nxt;
  logic signed [PE_W-1:0]        est_sum;
  logic signed [DATA_W-1:0]      est_nxt;

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (pred_r),
    .den   (den),
    .done  (sts.div_done),
    .quot  (quot)
  );

  always_comb begin
    // predicted covariance saturates at all ones
    pred_sum = {1'b0, cov_r} + {1'b0, cfg_q};
    pred_nxt = pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];
    den      = {1'b0, pred_r} + {1'b0, cfg_r};

    sfix_wide = $signed({{(XW-SAMPLE_BITS){samp_r[SAMPLE_BITS-1]}}, samp_r}) <<< FRAC_BITS;
    if (sfix_wide > SMAX) begin
      sfix = SMAX[DATA_W-1:0];
    end else if (sfix_wide < SMIN) begin
      sfix = SMIN[DATA_W-1:0];
    end else begin
      sfix = sfix_wide[DATA_W-1:0];
    end
    innov = {sfix[DATA_W-1], sfix} - {est_r[DATA_W-1], est_r};

    prod_est_nxt = $signed({1'b0, quot}) * innov;
    prod_cov_nxt = {{DATA_W{1'b0}}, GAIN_ONE - quot} * {{GAIN_W{1'b0}}, pred_r};

    // arithmetic shift rounds the step toward minus infinity
    est_sum = (prod_est_r >>> GAIN_FRAC) + PE_W'(est_r);
    if (est_sum > EMAX) begin
      est_nxt = EMAX[DATA_W-1:0];
    end else if (est_sum < EMIN) begin
      est_nxt = EMIN[DATA_W-1:0];
    end else begin
      est_nxt = est_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r <= '0;
      cov_r <= P0_RST;
    end else if (init_we) begin
      est_r <= '0;
      cov_r <= init_val;
    end else if (cmd.upd_en) begin
      est_r <= est_nxt;
      cov_r <= prod_cov_r[GAIN_FRAC +: DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      samp_r <= sample_in;
      pred_r <= pred_nxt;
    end
    if (cmd.mul_en) begin
      prod_est_r <= prod_est_nxt;
      prod_cov_r <= prod_cov_nxt;
      gain_r     <= quot;
    end
    if (cmd.upd_en) begin
      out_gain_r <= gain_r;
    end
  end

  // estimate moves on an update, which waits for a free output register, and on init
  assign est_out  = est_r;
  assign gain_out = out_gain_r;

endmodule

@@ rtl/skf_ctrl.sv @@
// controller: sequences one sample through predict, divide, multiply and update
// depends on skf_pkg
module skf_ctrl import skf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output skf_cmd_t cmd,
  input  skf_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd.load_in   = in_tvalid && in_tready;
    cmd.div_start = (state_r == S_LOAD);
    cmd.mul_en    = (state_r == S_MUL);
    cmd.upd_en    = (state_r == S_UPD) && (!out_valid_r || out_tready);

    out_valid_nxt = out_valid_r;
    if (cmd.upd_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load_in) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (cmd.upd_en) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  a_div_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |=> state_r == S_DIV && !sts.div_done)
    else $error("divider reported done right after start");

  a_result_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_UPD)
    else $error("result appeared without an update");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_LOAD && !in_tready)
    else $error("accepted request did not start processing");
`endif

endmodule

@@ rtl/scalar_kalman_filter.sv @@
// scalar kalman filter, one request per sample, one result per sample
// the result shows on out_tvalid once the sample has passed load, the 17-step
// restoring gain divider, multiply and update; no new sample is taken before then
// a finished result may wait in the output register while the next sample is taken
// reset (rst_n, synchronous): Q=1, R=1.0, initial covariance=1.0, estimate cleared
// writing the initial covariance reloads the covariance and clears the estimate
module scalar_kalman_filter import skf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,    // sample
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((DATA_W+GAIN_W+7)/8)*8-1:0]    out_tdata,   // estimate, gain
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [ADDR_W-1:0]                     cfg_paddr,
  input  logic [DATA_W-1:0]                     cfg_pwdata,
  output logic [DATA_W-1:0]                     cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int OUT_W = ((DATA_W + GAIN_W + 7) / 8) * 8;

  logic [DATA_W-1:0]    q_r;
  logic [DATA_W-1:0]    r_r;
  logic [DATA_W-1:0]    p0_r;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 init_we;
  skf_cmd_t             cmd;
  skf_sts_t             sts;
  logic [DATA_W-1:0]    est;
  logic [GAIN_W-1:0]    gain;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign init_we    = cfg_we && (cfg_idx == REG_P0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= Q_RST;
      r_r  <= R_RST;
      p0_r <= P0_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_Q:   q_r  <= cfg_pwdata;
        REG_R:   r_r  <= cfg_pwdata;
        REG_P0:  p0_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_Q:   cfg_prdata = q_r;
      REG_R:   cfg_prdata = r_r;
      REG_P0:  cfg_prdata = p0_r;
      default: cfg_prdata = '0;
    endcase
  end

  skf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  skf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .sample_in (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_q     (q_r),
    .cfg_r     (r_r),
    .init_we   (init_we),
    .init_val  (cfg_pwdata),
    .est_out   (est),
    .gain_out  (gain)
  );

  assign out_tdata = {{(OUT_W-DATA_W-GAIN_W){1'b0}}, gain, est};

endmodule
